// ----- rtl/boxds_pkg.sv -----
// Package for the 2x2 box-average downscaler: sizes, register codes, reset values
// and the control struct passed between the pipeline stages. No dependencies.
`default_nettype none

package boxds_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = 12;
	localparam int HGT_W      = 16;
	localparam int CMP_W      = (WID_W > COL_W + 1) ? WID_W : COL_W + 1;
	localparam int ROW_CMP_W  = HGT_W + 1;
	localparam int PIX_W      = 8;
	localparam int LANE_W     = PIX_W + 1;
	localparam int SUM_W      = 3 * LANE_W;
	localparam int ADDR_W     = 3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
	localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

	typedef struct packed {
		logic             valid;
		logic             emit;
		logic             wr;
		logic             last;
		logic [IDX_W-1:0] idx;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/box_average_downscale_2x.sv -----
// Top level of the 2x2 box-average downscaler: APB registers, input stage,
// line buffer RAM and output stage. Depends on boxds_pkg, boxds_front, boxds_ram, boxds_back.
// Throughput: one pixel per cycle while out_ready does not stall; output valid is registered.
// The line buffer read is registered, so the vertical sum forms in the cycle after acceptance.
// Reset (arst_n low, asynchronous): counters, held pixel and valids clear, width 640,
// height 480; line buffer contents are undefined until written, with no clearing pass.
`default_nettype none

module box_average_downscale_2x
	import boxds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [PIX_W-1:0]  red_in,
	input  wire logic [PIX_W-1:0]  green_in,
	input  wire logic [PIX_W-1:0]  blue_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [PIX_W-1:0]  red_out,
	output logic      [PIX_W-1:0]  green_out,
	output logic      [PIX_W-1:0]  blue_out,
	output logic                   frame_last
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic             s1_free;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [SUM_W-1:0] rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [SUM_W-1:0] wr_data;
	ctrl_t            ctrl_s1;
	logic [SUM_W-1:0] pair_s1;

	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HGT_W-1:0];
				default:    ;
			endcase
		end
	end

	boxds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.width_q  (width_q),
		.height_q (height_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.s1_free  (s1_free),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.ctrl_s1  (ctrl_s1),
		.pair_s1  (pair_s1)
	);

	boxds_ram #(
		.WIDTH (SUM_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	boxds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s1    (ctrl_s1),
		.pair_s1    (pair_s1),
		.rd_data    (rd_data),
		.s1_free    (s1_free),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

// ----- rtl/boxds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module boxds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/boxds_front.sv -----
// Input stage: frame counters, held even-column pixel, horizontal pair sum and
// line buffer read request. Depends on boxds_pkg.
`default_nettype none

module boxds_front
	import boxds_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [WID_W-1:0]   width_q,
	input  wire logic [HGT_W-1:0]   height_q,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PIX_W-1:0]   red_in,
	input  wire logic [PIX_W-1:0]   green_in,
	input  wire logic [PIX_W-1:0]   blue_in,
	input  wire logic               s1_free,
	output logic                    rd_en,
	output logic      [IDX_W-1:0]   rd_addr,
	output ctrl_t                   ctrl_s1,
	output logic      [SUM_W-1:0]   pair_s1
);

	logic [COL_W-1:0]     col_q;
	logic [HGT_W-1:0]     row_q;
	logic [3*PIX_W-1:0]   held_q;
	logic [CMP_W-1:0]     w_raw;
	logic [CMP_W-1:0]     w_eff;
	logic [CMP_W-1:0]     col_ext;
	logic [ROW_CMP_W-1:0] h_eff;
	logic [ROW_CMP_W-1:0] row_ext;
	logic                 col_wrap;
	logic                 row_wrap;
	logic                 last_col;
	logic                 last_row;
	logic                 in_accept;
	logic [SUM_W-1:0]     pair;

	assign w_raw   = CMP_W'(width_q);
	assign w_eff   = (w_raw == '0) ? CMP_W'(1) :
	                 (w_raw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_raw;
	assign h_eff   = (height_q == '0) ? ROW_CMP_W'(1) : ROW_CMP_W'(height_q);
	assign col_ext = CMP_W'(col_q);
	assign row_ext = ROW_CMP_W'(row_q);

	assign col_wrap = (col_ext + CMP_W'(1)) >= w_eff;
	assign row_wrap = (row_ext + ROW_CMP_W'(1)) >= h_eff;
	assign last_col = col_ext == ((w_eff & ~CMP_W'(1)) - CMP_W'(1));
	assign last_row = row_ext == ((h_eff & ~ROW_CMP_W'(1)) - ROW_CMP_W'(1));

	assign in_ready  = !ctrl_s1.valid || s1_free;
	assign in_accept = in_valid && in_ready;

	assign pair[LANE_W-1:0]          = LANE_W'(held_q[PIX_W-1:0]) + LANE_W'(red_in);
	assign pair[2*LANE_W-1:LANE_W]   = LANE_W'(held_q[2*PIX_W-1:PIX_W]) + LANE_W'(green_in);
	assign pair[3*LANE_W-1:2*LANE_W] = LANE_W'(held_q[3*PIX_W-1:2*PIX_W]) + LANE_W'(blue_in);

	assign rd_en   = in_accept && col_q[0] && row_q[0];
	assign rd_addr = col_q[IDX_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			held_q  <= '0;
			ctrl_s1 <= '0;
		end else begin
			if (in_ready) begin
				ctrl_s1.valid <= in_accept;
			end
			if (in_accept) begin
				ctrl_s1.emit <= col_q[0] && row_q[0];
				ctrl_s1.wr   <= col_q[0] && !row_q[0];
				ctrl_s1.last <= last_col && last_row;
				ctrl_s1.idx  <= col_q[IDX_W:1];
				if (!col_q[0]) begin
					held_q <= {blue_in, green_in, red_in};
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + HGT_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pair_s1 <= pair;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/boxds_back.sv -----
// Output stage: line buffer write of even-row pair sums, vertical sum with the
// stored row, truncating divide by four and the output register. Depends on boxds_pkg.
`default_nettype none

module boxds_back
	import boxds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctrl_t            ctrl_s1,
	input  wire logic [SUM_W-1:0] pair_s1,
	input  wire logic [SUM_W-1:0] rd_data,
	output logic                  s1_free,
	output logic                  wr_en,
	output logic      [IDX_W-1:0] wr_addr,
	output logic      [SUM_W-1:0] wr_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [PIX_W-1:0] red_out,
	output logic      [PIX_W-1:0] green_out,
	output logic      [PIX_W-1:0] blue_out,
	output logic                  frame_last
);

	logic [LANE_W:0] sum_r;
	logic [LANE_W:0] sum_g;
	logic [LANE_W:0] sum_b;

	assign s1_free = !out_valid || out_ready;

	assign wr_en   = ctrl_s1.valid && ctrl_s1.wr && s1_free;
	assign wr_addr = ctrl_s1.idx;
	assign wr_data = pair_s1;

	assign sum_r = (LANE_W + 1)'(rd_data[LANE_W-1:0]) +
	               (LANE_W + 1)'(pair_s1[LANE_W-1:0]);
	assign sum_g = (LANE_W + 1)'(rd_data[2*LANE_W-1:LANE_W]) +
	               (LANE_W + 1)'(pair_s1[2*LANE_W-1:LANE_W]);
	assign sum_b = (LANE_W + 1)'(rd_data[3*LANE_W-1:2*LANE_W]) +
	               (LANE_W + 1)'(pair_s1[3*LANE_W-1:2*LANE_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_free) begin
			out_valid <= ctrl_s1.valid && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && ctrl_s1.valid && ctrl_s1.emit) begin
			red_out    <= sum_r[LANE_W:2];
			green_out  <= sum_g[LANE_W:2];
			blue_out   <= sum_b[LANE_W:2];
			frame_last <= ctrl_s1.last;
		end
	end

endmodule

`default_nettype wire
